### src/lsfe_pkg.sv
// lsfe_pkg: shared types and constants of the led strip frame encoder
// holds command and result types, mode codes and register indexes
// no dependencies
`default_nettype none

package lsfe_pkg;

  localparam logic [2:0] MODE_SET_COLOR = 3'd0;
  localparam logic [2:0] MODE_FADE_IN   = 3'd1;
  localparam logic [2:0] MODE_FADE_OUT  = 3'd2;
  localparam logic [2:0] MODE_ALL_OFF   = 3'd3;
  localparam logic [2:0] MODE_UPDATE    = 3'd4;
  localparam logic [2:0] MODE_NEXT_SLOT = 3'd5;

  localparam logic       CFG_LEVEL_ONE  = 1'b0;
  localparam logic       CFG_LEVEL_ZERO = 1'b1;

  localparam logic [7:0] LEVEL_ONE_RST  = 8'd58;
  localparam logic [7:0] LEVEL_ZERO_RST = 8'd29;

  localparam logic [4:0] LAST_BIT = 5'd23;

  typedef enum logic [2:0] {
    OP_SET,
    OP_FADE_IN,
    OP_FADE_OUT,
    OP_CLEAR,
    OP_COPY,
    OP_SLOT,
    OP_NOP
  } lsfe_op_t;

  typedef struct packed {
    lsfe_op_t    op;
    logic [5:0]  idx;
    logic [23:0] row;
    logic [7:0]  step;
  } lsfe_cmd_t;

  typedef struct packed {
    logic [7:0] duty;
    logic       reset_slot;
    logic       last_slot;
  } lsfe_res_t;

  typedef struct packed {
    logic init_busy;
    logic take;
  } lsfe_bstat_t;

endpackage

`default_nettype wire

### src/lsfe_front.sv
// lsfe_front: accepts input transactions, decodes them into commands
// and holds them in a two-entry command queue; uses lsfe_pkg
`default_nettype none

module lsfe_front import lsfe_pkg::*; #(
  parameter int LED_COUNT = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  output logic             full,
  input  wire logic [2:0]  in_mode,
  input  wire logic [5:0]  in_led_index,
  input  wire logic [7:0]  in_red,
  input  wire logic [7:0]  in_green,
  input  wire logic [7:0]  in_blue,
  input  wire logic [7:0]  in_fade_step,
  output logic             cmd_vld,
  output lsfe_cmd_t        cmd,
  input  wire lsfe_bstat_t bstat
);

  lsfe_cmd_t  q_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  lsfe_cmd_t  dec;
  logic       accept;

  always_comb begin
    dec.idx  = in_led_index;
    dec.row  = {in_green, in_red, in_blue};
    dec.step = in_fade_step;
    unique case (in_mode)
      MODE_SET_COLOR: begin
        dec.op = ({5'd0, in_led_index} < 11'(LED_COUNT)) ? OP_SET : OP_NOP;
      end
      MODE_FADE_IN:   dec.op = OP_FADE_IN;
      MODE_FADE_OUT:  dec.op = OP_FADE_OUT;
      MODE_ALL_OFF:   dec.op = OP_CLEAR;
      MODE_UPDATE:    dec.op = OP_COPY;
      MODE_NEXT_SLOT: dec.op = OP_SLOT;
      default:        dec.op = OP_NOP;
    endcase
  end

  assign full    = (count_r == 2'd2) || bstat.init_busy;
  assign accept  = push && !full;
  assign cmd_vld = (count_r != 2'd0);
  assign cmd     = q_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (accept) begin
      q_r[wr_ptr_r] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (accept) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (bstat.take) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      count_r <= count_r + 2'(accept) - 2'(bstat.take);
    end
  end

  a_take_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
    bstat.take |-> cmd_vld) else $error("command taken from empty queue");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd3) else $error("command queue count overflow");
  a_no_accept_in_init: assert property (@(posedge clk) disable iff (!rst_n)
    bstat.init_busy |-> !accept) else $error("transaction accepted during clearing");

endmodule

`default_nettype wire

### src/lsfe_rq.sv
// lsfe_rq: two-entry result queue between the engine and the result port
// uses lsfe_pkg for the result type
`default_nettype none

module lsfe_rq import lsfe_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      wr_en,
  input  wire lsfe_res_t wr_data,
  output logic           q_full,
  output logic           empty,
  input  wire logic      pop,
  output lsfe_res_t      head
);

  lsfe_res_t  q_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic       rd_en;

  assign q_full = (count_r == 2'd2);
  assign empty  = (count_r == 2'd0);
  assign rd_en  = pop && !empty;
  assign head   = q_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      q_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (rd_en) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      count_r <= count_r + 2'(wr_en) - 2'(rd_en);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> !q_full) else $error("result queue overflow");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd3) else $error("result queue count out of range");
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && !rd_en) |=> !empty) else $error("result lost after write");

endmodule

`default_nettype wire

### src/lsfe_back.sv
// lsfe_back: command engine with the working and shown row memories
// runs the row sweeps, the slot counter and the post-reset clearing pass; uses lsfe_pkg
`default_nettype none

module lsfe_back import lsfe_pkg::*; #(
  parameter int LED_COUNT    = 64,
  parameter int RESET_GROUPS = 2
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cmd_vld,
  input  wire lsfe_cmd_t  cmd,
  output lsfe_bstat_t     bstat,
  input  wire logic [7:0] level_one,
  input  wire logic [7:0] level_zero,
  input  wire logic       rq_full,
  output logic            res_push,
  output lsfe_res_t       res
);

  localparam int AW        = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  localparam int LED_TOTAL = LED_COUNT + RESET_GROUPS;
  localparam int LW        = $clog2(LED_TOTAL);

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_FINISH,
    S_SWEEP,
    S_DRAIN,
    S_SLOT_RD,
    S_SLOT_OUT
  } state_t;

  function automatic logic [7:0] sat_add(input logic [7:0] v, input logic [7:0] s);
    logic [8:0] sum;
    sum = {1'b0, v} + {1'b0, s};
    return sum[8] ? 8'hFF : sum[7:0];
  endfunction

  function automatic logic [7:0] floor_sub(input logic [7:0] v, input logic [7:0] s);
    return (v > s) ? (v - s) : 8'd0;
  endfunction

  logic [23:0]     work_mem  [LED_COUNT];
  logic [23:0]     shown_mem [LED_COUNT];
  logic [23:0]     work_rd_r;
  logic [23:0]     shown_rd_r;

  state_t          state_r;
  lsfe_cmd_t       cmd_r;
  logic [AW-1:0]   sw_addr_r;
  logic            pipe_vld_r;
  logic [AW-1:0]   pipe_addr_r;
  logic [LW-1:0]   slot_led_r;
  logic [4:0]      slot_bit_r;
  logic [4:0]      bit_hold_r;
  logic            is_rst_r;
  logic            is_last_r;

  logic            take;
  logic            sw_last;
  logic            slot_data;
  logic            slot_last;
  logic [15:0]     idx_ext;

  logic            work_we;
  logic [AW-1:0]   work_wa;
  logic [23:0]     work_wd;
  logic            work_re;
  logic            shown_we;
  logic [AW-1:0]   shown_wa;
  logic            shown_re;
  logic [23:0]     faded;

  assign take      = (state_r == S_IDLE) && cmd_vld && !rq_full;
  assign sw_last   = (sw_addr_r == AW'(LED_COUNT - 1));
  assign slot_data = (slot_led_r < LW'(LED_COUNT));
  assign slot_last = (slot_led_r == LW'(LED_TOTAL - 1)) && (slot_bit_r == LAST_BIT);
  assign idx_ext   = 16'(cmd_r.idx);

  assign bstat.init_busy = (state_r == S_INIT);
  assign bstat.take      = take;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (cmd_r.op == OP_FADE_IN) begin
        faded[i*8 +: 8] = sat_add(work_rd_r[i*8 +: 8], cmd_r.step);
      end else begin
        faded[i*8 +: 8] = floor_sub(work_rd_r[i*8 +: 8], cmd_r.step);
      end
    end
  end

  always_comb begin
    work_we  = 1'b0;
    work_wa  = pipe_addr_r;
    work_wd  = 24'd0;
    shown_we = 1'b0;
    shown_wa = pipe_addr_r;
    work_re  = (state_r == S_SWEEP);
    shown_re = (state_r == S_SLOT_RD) && slot_data;
    if (state_r == S_INIT) begin
      work_we  = 1'b1;
      work_wa  = sw_addr_r;
      shown_we = 1'b1;
      shown_wa = sw_addr_r;
    end else if ((state_r == S_FINISH) && (cmd_r.op == OP_SET)) begin
      work_we = 1'b1;
      work_wa = idx_ext[AW-1:0];
      work_wd = cmd_r.row;
    end else if (pipe_vld_r) begin
      case (cmd_r.op) inside
        OP_FADE_IN, OP_FADE_OUT: begin
          work_we = 1'b1;
          work_wd = faded;
        end
        OP_CLEAR: begin
          work_we = 1'b1;
        end
        OP_COPY: begin
          shown_we = 1'b1;
        end
        default: begin
          work_we = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (work_we) begin
      work_mem[work_wa] <= work_wd;
    end
    if (work_re) begin
      work_rd_r <= work_mem[sw_addr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (shown_we) begin
      shown_mem[shown_wa] <= work_rd_r & {24{(state_r != S_INIT)}};
    end
    if (shown_re) begin
      shown_rd_r <= shown_mem[slot_led_r[AW-1:0]];
    end
  end

  always_comb begin
    res_push       = 1'b0;
    res.duty       = 8'd0;
    res.reset_slot = 1'b0;
    res.last_slot  = 1'b0;
    unique case (state_r) inside
      S_FINISH, S_DRAIN: res_push = 1'b1;
      S_SLOT_OUT: begin
        res_push       = 1'b1;
        res.reset_slot = is_rst_r;
        res.last_slot  = is_last_r;
        if (!is_rst_r) begin
          res.duty = shown_rd_r[LAST_BIT - bit_hold_r] ? level_one : level_zero;
        end
      end
      default: res_push = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_INIT;
      sw_addr_r  <= '0;
      pipe_vld_r <= 1'b0;
      slot_led_r <= '0;
      slot_bit_r <= 5'd0;
    end else begin
      unique case (state_r)
        S_INIT: begin
          sw_addr_r <= AW'(sw_addr_r + 1'b1);
          if (sw_last) begin
            sw_addr_r <= '0;
            state_r   <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (take) begin
            cmd_r     <= cmd;
            sw_addr_r <= '0;
            unique case (cmd.op) inside
              OP_FADE_IN, OP_FADE_OUT, OP_CLEAR, OP_COPY: state_r <= S_SWEEP;
              OP_SLOT: state_r <= S_SLOT_RD;
              default: state_r <= S_FINISH;
            endcase
          end
        end
        S_FINISH: begin
          state_r <= S_IDLE;
        end
        S_SWEEP: begin
          pipe_vld_r  <= 1'b1;
          pipe_addr_r <= sw_addr_r;
          sw_addr_r   <= AW'(sw_addr_r + 1'b1);
          if (sw_last) begin
            state_r <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          pipe_vld_r <= 1'b0;
          state_r    <= S_IDLE;
        end
        S_SLOT_RD: begin
          bit_hold_r <= slot_bit_r;
          is_rst_r   <= !slot_data;
          is_last_r  <= slot_last;
          if (slot_last) begin
            slot_led_r <= '0;
            slot_bit_r <= 5'd0;
          end else if (slot_bit_r == LAST_BIT) begin
            slot_led_r <= LW'(slot_led_r + 1'b1);
            slot_bit_r <= 5'd0;
          end else begin
            slot_bit_r <= slot_bit_r + 5'd1;
          end
          state_r <= S_SLOT_OUT;
        end
        S_SLOT_OUT: begin
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !rq_full) else $error("result pushed into full queue");
  a_slot_bit_range: assert property (@(posedge clk) disable iff (!rst_n)
    slot_bit_r <= LAST_BIT) else $error("slot bit counter out of range");
  a_slot_led_range: assert property (@(posedge clk) disable iff (!rst_n)
    int'(slot_led_r) < LED_TOTAL) else $error("slot led counter out of range");
  a_last_in_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (res_push && res.last_slot) |-> res.reset_slot)
    else $error("last slot outside reset gap");
  a_init_no_push: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_INIT) |-> !res_push) else $error("result during clearing pass");

endmodule

`default_nettype wire

### src/led_strip_frame_encoder_unit.sv
// led strip frame encoder: queue-style command input, slot result queue and
// two level registers. Input push/full: one transaction per accepted command
// (set color, fade in, fade out, all off, update, next slot). Result empty/pop:
// exactly one result per command, in order; non-slot commands return zeros.
// Next slot returns the compare value of the next bit of the shown buffer,
// green, red, blue, msb first, then RESET_GROUPS leds of zero reset slots.
// Commands are decoded into a two-entry queue and run one at a time by the
// engine: set color and unused modes via the finish state, next slot via the
// slot read and output states, fade in, fade out, all off and update by a
// sweep of all rows through the one-row-per-cycle working memory port. A
// pushed command is registered in the queue first. After reset both buffers
// are cleared in a pass over every row, with full held high; config writes
// are taken meanwhile. If the receiver stalls, the result queue fills after
// two results, the engine waits and full rises once the command queue holds
// two commands. A level write takes effect at once, so the user must write
// levels only while no command is in flight; the block does not enforce it.
// uses lsfe_pkg, lsfe_front, lsfe_back and lsfe_rq
`default_nettype none

module led_strip_frame_encoder_unit import lsfe_pkg::*; #(
  parameter int LED_COUNT    = 64,
  parameter int RESET_GROUPS = 2
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  output logic            full,
  input  wire logic [2:0] in_mode,
  input  wire logic [5:0] in_led_index,
  input  wire logic [7:0] in_red,
  input  wire logic [7:0] in_green,
  input  wire logic [7:0] in_blue,
  input  wire logic [7:0] in_fade_step,
  output logic            empty,
  input  wire logic       pop,
  output logic [7:0]      out_duty,
  output logic            out_reset_slot,
  output logic            out_last_slot,
  input  wire logic       cfg_wr_en,
  input  wire logic       cfg_index,
  input  wire logic [7:0] cfg_data
);

  logic [7:0]  level_one_r;
  logic [7:0]  level_zero_r;
  logic        cmd_vld;
  lsfe_cmd_t   cmd;
  lsfe_bstat_t bstat;
  logic        rq_full;
  logic        res_push;
  lsfe_res_t   res;
  lsfe_res_t   head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_one_r  <= LEVEL_ONE_RST;
      level_zero_r <= LEVEL_ZERO_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_LEVEL_ONE:  level_one_r  <= cfg_data;
        CFG_LEVEL_ZERO: level_zero_r <= cfg_data;
        default:        level_one_r  <= level_one_r;
      endcase
    end
  end

  lsfe_front #(.LED_COUNT(LED_COUNT)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .full         (full),
    .in_mode      (in_mode),
    .in_led_index (in_led_index),
    .in_red       (in_red),
    .in_green     (in_green),
    .in_blue      (in_blue),
    .in_fade_step (in_fade_step),
    .cmd_vld      (cmd_vld),
    .cmd          (cmd),
    .bstat        (bstat)
  );

  lsfe_back #(.LED_COUNT(LED_COUNT), .RESET_GROUPS(RESET_GROUPS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_vld    (cmd_vld),
    .cmd        (cmd),
    .bstat      (bstat),
    .level_one  (level_one_r),
    .level_zero (level_zero_r),
    .rq_full    (rq_full),
    .res_push   (res_push),
    .res        (res)
  );

  lsfe_rq u_rq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_push),
    .wr_data (res),
    .q_full  (rq_full),
    .empty   (empty),
    .pop     (pop),
    .head    (head)
  );

  assign out_duty       = head.duty;
  assign out_reset_slot = head.reset_slot;
  assign out_last_slot  = head.last_slot;

endmodule

`default_nettype wire
